>>> rtl/ipag_pkg.sv
// shared types, widths, register codes and defaults for the im2col patch address generator
package ipag_pkg;

  // parameter defaults
  localparam int MAX_DIM_DEF      = 256;
  localparam int MAX_KERNEL_DEF   = 8;
  localparam int MAX_CHANNELS_DEF = 1024;
  localparam int QUEUE_DEPTH_DEF  = 4;

  // field widths
  localparam int CHAN_W     = 10;
  localparam int ROW_W      = 8;
  localparam int DIM_W      = 9;
  localparam int KERN_W     = 4;
  localparam int STEP_W     = 4;
  localparam int PAD_W      = 3;
  localparam int ADDR_W     = 26;
  localparam int DST_W      = 16;
  localparam int TAP_W      = 6;
  localparam int POS_W      = 12;  // out_row * stride
  localparam int SPOS_W     = 13;  // signed tap position
  localparam int AREA_W     = 18;  // h * w
  localparam int KSIZE_W    = 8;   // kh * kw
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERN_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KERN_WIDTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_STRIDE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZ_STRIDE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_PAD      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_PAD     = 3'd7;

  typedef struct packed {
    logic [CHAN_W-1:0] chan;
    logic [ROW_W-1:0]  out_row;
    logic [ROW_W-1:0]  out_col;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] src_addr;
    logic [DST_W-1:0]  dst_column;
    logic [TAP_W-1:0]  tap_index;
    logic              in_bounds;
    logic              last_tap;
  } out_item_t;

  // saturated configuration plus derived products
  typedef struct packed {
    logic [DIM_W-1:0]    h;
    logic [DIM_W-1:0]    w;
    logic [KERN_W-1:0]   kh;
    logic [KERN_W-1:0]   kw;
    logic [STEP_W-1:0]   vs;
    logic [STEP_W-1:0]   hs;
    logic [PAD_W-1:0]    tpad;
    logic [PAD_W-1:0]    lpad;
    logic [AREA_W-1:0]   area;
    logic [KSIZE_W-1:0]  ksize;
  } cfg_t;

  // one patch as handed from front to back
  typedef struct packed {
    logic [ADDR_W-1:0]        row_base;  // chan*h*w + r0*w, modulo address width
    logic [DST_W-1:0]         dst_base;  // chan*ksize
    logic signed [SPOS_W-1:0] r0;
    logic signed [SPOS_W-1:0] c0;
  } desc_t;

endpackage

>>> rtl/im2col_patch_address_generator_top.sv
// top level of the im2col patch address generator
// A request (channel, output row, output column) produces one result per kernel tap in
// row-major order: the flat source address in the channel-planar image, the im2col
// destination column, the tap index, an in-bounds flag (clear for padding taps, whose
// address reads zero) and a last marker on the final tap. Requests whose column start
// lies at or past the image width, whose channel is out of range or whose kernel has a
// zero dimension are taken and produce nothing. Throughput is one result per cycle while
// out_stall is low: the tap sequencer emits one tap per cycle and loads the next queued
// patch under the last tap of the current one. The front end is a three-stage pipeline
// (stages a, b and c) that takes one request per cycle while the descriptor queue has
// room. The output is registered and a full output register does not block the front end.
// Configuration writes are always ready and are meant for idle periods only; there is
// no clearing pass after reset.
module im2col_patch_address_generator_top #(
  parameter int MAX_DIM      = ipag_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL   = ipag_pkg::MAX_KERNEL_DEF,
  parameter int MAX_CHANNELS = ipag_pkg::MAX_CHANNELS_DEF,
  parameter int QUEUE_DEPTH  = ipag_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ipag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipag_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // patch requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  ipag_pkg::in_item_t              in_data,
  // tap results
  output logic                            out_valid,
  input  logic                            out_stall,
  output ipag_pkg::out_item_t             out_data
);
  import ipag_pkg::*;

  cfg_t  cfg;
  logic  q_push, q_full, q_pop, q_empty;
  desc_t q_wr_data, q_rd_data;

  // registers never push back
  assign cfg_ready = 1'b1;

  ipag_cfg #(
    .MAX_DIM    (MAX_DIM),
    .MAX_KERNEL (MAX_KERNEL)
  ) u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  // front end: drop empty requests, compute patch base addresses
  ipag_front #(
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_wr_data),
    .q_full   (q_full)
  );

  // decouples request acceptance from tap emission
  ipag_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (q_wr_data),
    .full    (q_full),
    .pop     (q_pop),
    .rd_data (q_rd_data),
    .empty   (q_empty)
  );

  // back end: one tap per output transfer
  ipag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_data    (q_rd_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> rtl/ipag_cfg.sv
// configuration registers with saturation and derived image area and kernel size
module ipag_cfg #(
  parameter int MAX_DIM    = ipag_pkg::MAX_DIM_DEF,
  parameter int MAX_KERNEL = ipag_pkg::MAX_KERNEL_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [ipag_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [ipag_pkg::CFG_DATA_W-1:0]  wr_data,
  output ipag_pkg::cfg_t                   cfg
);
  import ipag_pkg::*;

  logic [DIM_W-1:0]    h_r, w_r;
  logic [KERN_W-1:0]   kh_r, kw_r;
  logic [STEP_W-1:0]   vs_r, hs_r;
  logic [PAD_W-1:0]    tpad_r, lpad_r;
  logic [AREA_W-1:0]   area_r;
  logic [KSIZE_W-1:0]  ksize_r;
  logic [DIM_W-1:0]    h_sat, w_sat;
  logic [KERN_W-1:0]   kh_sat, kw_sat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r    <= DIM_W'(7);
      w_r    <= DIM_W'(7);
      kh_r   <= KERN_W'(3);
      kw_r   <= KERN_W'(3);
      vs_r   <= STEP_W'(1);
      hs_r   <= STEP_W'(1);
      tpad_r <= '0;
      lpad_r <= '0;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_IN_HEIGHT:    h_r    <= wr_data;
        REG_IN_WIDTH:     w_r    <= wr_data;
        REG_KERN_HEIGHT:  kh_r   <= wr_data[KERN_W-1:0];
        REG_KERN_WIDTH:   kw_r   <= wr_data[KERN_W-1:0];
        REG_VERT_STRIDE:  vs_r   <= wr_data[STEP_W-1:0];
        REG_HORIZ_STRIDE: hs_r   <= wr_data[STEP_W-1:0];
        REG_TOP_PAD:      tpad_r <= wr_data[PAD_W-1:0];
        REG_LEFT_PAD:     lpad_r <= wr_data[PAD_W-1:0];
      endcase
    end
  end

  // oversized dimensions clamp to the build limits
  assign h_sat  = (32'(h_r)  > MAX_DIM)    ? DIM_W'(MAX_DIM)     : h_r;
  assign w_sat  = (32'(w_r)  > MAX_DIM)    ? DIM_W'(MAX_DIM)     : w_r;
  assign kh_sat = (32'(kh_r) > MAX_KERNEL) ? KERN_W'(MAX_KERNEL) : kh_r;
  assign kw_sat = (32'(kw_r) > MAX_KERNEL) ? KERN_W'(MAX_KERNEL) : kw_r;

  // products refresh every cycle and are registered, ready in the cycle after any write lands
  always_ff @(posedge clk) begin
    area_r  <= AREA_W'(h_sat) * AREA_W'(w_sat);
    ksize_r <= KSIZE_W'(kh_sat) * KSIZE_W'(kw_sat);
  end

  always_comb begin
    cfg.h     = h_sat;
    cfg.w     = w_sat;
    cfg.kh    = kh_sat;
    cfg.kw    = kw_sat;
    cfg.vs    = vs_r;
    cfg.hs    = hs_r;
    cfg.tpad  = tpad_r;
    cfg.lpad  = lpad_r;
    cfg.area  = area_r;
    cfg.ksize = ksize_r;
  end

endmodule

>>> rtl/ipag_front.sv
// request front end: filter, stride and padding offsets, base address products
module ipag_front #(
  parameter int MAX_CHANNELS = ipag_pkg::MAX_CHANNELS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ipag_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_stall,
  input  ipag_pkg::in_item_t in_data,
  output logic               q_push,
  output ipag_pkg::desc_t    q_data,
  input  logic               q_full
);
  import ipag_pkg::*;

  localparam int PROD_W = CHAN_W + AREA_W;
  localparam int DPROD_W = CHAN_W + KSIZE_W;
  localparam int RW_W = SPOS_W + DIM_W + 1;

  // stage a
  logic              a_vld_r;
  logic [CHAN_W-1:0] a_chan_r;
  logic [POS_W-1:0]  a_row0_r, a_col0_r;
  // stage b
  logic                     b_vld_r;
  logic [ADDR_W-1:0]        b_chan_base_r;
  logic signed [RW_W-1:0]   b_rw0_r;
  logic signed [SPOS_W-1:0] b_r0_r, b_c0_r;
  logic [DST_W-1:0]         b_dst_r;
  // stage c
  logic  c_vld_r;
  desc_t c_desc_r;

  logic                     rdy_a, rdy_b, rdy_c;
  logic [POS_W-1:0]         row0, col0;
  logic                     keep;
  logic [PROD_W-1:0]        cb_full;
  logic [DPROD_W-1:0]       db_full;
  logic signed [SPOS_W-1:0] r0, c0;
  logic signed [RW_W-1:0]   rw0;

  assign rdy_c    = !c_vld_r || !q_full;
  assign rdy_b    = !b_vld_r || rdy_c;
  assign rdy_a    = !a_vld_r || rdy_b;
  assign in_stall = !rdy_a;

  assign row0 = POS_W'(in_data.out_row) * POS_W'(cfg.vs);
  assign col0 = POS_W'(in_data.out_col) * POS_W'(cfg.hs);
  // requests that emit nothing are dropped here
  assign keep = (32'(in_data.chan) < MAX_CHANNELS) && (cfg.kh != '0) && (cfg.kw != '0)
             && (col0 < POS_W'(cfg.w));

  assign cb_full = PROD_W'(a_chan_r) * PROD_W'(cfg.area);
  assign db_full = DPROD_W'(a_chan_r) * DPROD_W'(cfg.ksize);
  assign r0      = signed'(SPOS_W'(a_row0_r)) - signed'(SPOS_W'(cfg.tpad));
  assign c0      = signed'(SPOS_W'(a_col0_r)) - signed'(SPOS_W'(cfg.lpad));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else begin
      if (rdy_a) a_vld_r <= in_valid && keep;
      if (rdy_b) b_vld_r <= a_vld_r;
      if (rdy_c) c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) begin
      a_chan_r <= in_data.chan;
      a_row0_r <= row0;
      a_col0_r <= col0;
    end
    if (rdy_b) begin
      b_chan_base_r <= cb_full[ADDR_W-1:0];
      b_dst_r       <= db_full[DST_W-1:0];
      b_r0_r        <= r0;
      b_c0_r        <= c0;
    end
    if (rdy_c) begin
      c_desc_r.row_base <= b_chan_base_r + ADDR_W'(b_rw0_r);
      c_desc_r.dst_base <= b_dst_r;
      c_desc_r.r0       <= b_r0_r;
      c_desc_r.c0       <= b_c0_r;
    end
  end

  // first row offset, may be negative above the image
  assign rw0 = RW_W'(r0) * signed'(RW_W'(cfg.w));
  always_ff @(posedge clk) begin
    if (rdy_b) b_rw0_r <= rw0;
  end

  assign q_push = c_vld_r && !q_full;
  assign q_data = c_desc_r;

endmodule

>>> rtl/ipag_fifo.sv
// patch descriptor queue between front end and tap sequencer
module ipag_fifo #(
  parameter int DEPTH = ipag_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  ipag_pkg::desc_t wr_data,
  output logic            full,
  input  logic            pop,
  output ipag_pkg::desc_t rd_data,
  output logic            empty
);
  import ipag_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  desc_t            slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign full    = cnt_r == CNT_W'(DEPTH);
  assign empty   = cnt_r == '0;
  assign rd_data = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");

endmodule

>>> rtl/ipag_back.sv
// tap sequencer: walks the kernel of one patch and registers one result per cycle unless out_stall holds the output
module ipag_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ipag_pkg::cfg_t      cfg,
  input  logic                q_empty,
  input  ipag_pkg::desc_t     q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output ipag_pkg::out_item_t out_data
);
  import ipag_pkg::*;

  logic                     busy_r;
  logic [ADDR_W-1:0]        rb_r;
  logic signed [SPOS_W-1:0] r_r, c0_r;
  logic [KERN_W-1:0]        kr_r, kc_r;
  logic [KSIZE_W-1:0]       tap_r;
  logic [DST_W-1:0]         dst_r;
  logic                     out_vld_r;
  out_item_t                out_data_r;

  logic                     out_adv, tap_go, tap_last, row_end, load, inb;
  logic signed [SPOS_W-1:0] c;
  out_item_t                res;

  assign out_adv  = !out_vld_r || !out_stall;
  assign tap_go   = busy_r && out_adv;
  assign row_end  = kc_r == cfg.kw - 1'b1;
  assign tap_last = row_end && (kr_r == cfg.kh - 1'b1);
  // next patch loads under the last tap of the current one
  assign load     = !q_empty && (!busy_r || (tap_go && tap_last));
  assign q_pop    = load;

  assign c   = c0_r + signed'(SPOS_W'(kc_r));
  assign inb = !r_r[SPOS_W-1] && !c[SPOS_W-1]
            && (r_r[SPOS_W-2:0] < (SPOS_W-1)'(cfg.h))
            && (c[SPOS_W-2:0] < (SPOS_W-1)'(cfg.w));

  always_comb begin
    res.src_addr   = inb ? rb_r + ADDR_W'(c[SPOS_W-2:0]) : '0;
    res.dst_column = dst_r;
    res.tap_index  = tap_r[TAP_W-1:0];
    res.in_bounds  = inb;
    res.last_tap   = tap_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (load)                   busy_r <= 1'b1;
      else if (tap_go && tap_last) busy_r <= 1'b0;
      if (tap_go)        out_vld_r <= 1'b1;
      else if (!out_stall) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tap_go) out_data_r <= res;
    if (load) begin
      rb_r  <= q_data.row_base;
      r_r   <= q_data.r0;
      c0_r  <= q_data.c0;
      dst_r <= q_data.dst_base;
      tap_r <= '0;
      kr_r  <= '0;
      kc_r  <= '0;
    end else if (tap_go) begin
      tap_r <= tap_r + 1'b1;
      dst_r <= dst_r + 1'b1;
      if (row_end) begin
        kc_r <= '0;
        kr_r <= kr_r + 1'b1;
        r_r  <= r_r + 1'b1;
        rb_r <= rb_r + ADDR_W'(cfg.w);
      end else begin
        kc_r <= kc_r + 1'b1;
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  a_tap_matches_pos: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> tap_r == KSIZE_W'(kr_r) * KSIZE_W'(cfg.kw) + KSIZE_W'(kc_r))
    else $error("tap counter out of step with kernel position");

  a_pos_in_kernel: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (kr_r < cfg.kh) && (kc_r < cfg.kw))
    else $error("kernel position past kernel size");

  a_pad_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_data_r.in_bounds |-> out_data_r.src_addr == '0)
    else $error("padding tap with nonzero address");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    tap_go && tap_last && !load |=> !busy_r)
    else $error("sequencer busy after final tap");

endmodule
